[rtl/sars_pkg.sv]
// ----------------------------------------------------------------------------
// sars_pkg
// Types, constants and helpers of the square-root attitude rate shaper.
// ----------------------------------------------------------------------------
package sars_pkg;

	localparam int ANGLE_WIDTH_DEF = 16;

	localparam int ERR_W   = 16;
	localparam int RATE_W  = 16;
	localparam int GAIN_W  = 16;
	localparam int LIMIT_W = 15;
	localparam int CLIP_W  = 3;
	localparam int FRAC_W  = 12;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PEAK_GAIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT = 2'd1;

	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd7260;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd12868;

	// small-error region: |e| * 573 < 409600, i.e. |e| < 715
	localparam int SMALL_LIMIT = 715;
	localparam int SMALL_A_W   = 10;
	localparam int SMALL_NUM   = 573;
	localparam int F_W         = 19;
	localparam int P1_SMALL_W  = 27;

	// full divisor is 100 * 2^24: round offset, shift, then divide by 100
	localparam int ROUND_OFS   = 838860800;
	localparam int Q_SHIFT     = 24;
	localparam int RECIP       = 42949673;
	localparam int RECIP_W     = 26;
	localparam int RECIP_SHIFT = 32;
	localparam int ROUND_HALF  = 2048;

	localparam int POST_STAGES = 6;

	typedef struct packed {
		logic signed [ERR_W-1:0] err_roll;
		logic signed [ERR_W-1:0] err_pitch;
		logic signed [ERR_W-1:0] err_yaw;
	} err_vec_t;

	typedef struct packed {
		logic signed [RATE_W-1:0] rate_roll;
		logic signed [RATE_W-1:0] rate_pitch;
		logic signed [RATE_W-1:0] rate_yaw;
		logic [CLIP_W-1:0]        clip_mask;
	} rate_vec_t;

	function automatic int sqrt_w(input int angle_w);
		return (angle_w + FRAC_W + 1) / 2;
	endfunction

endpackage

[rtl/sars_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// sars_sqrt_cell
// One restoring square-root step: settles one root bit and hands the
// remainder, partial root, shifted radicand and side data to the next cell.
// ----------------------------------------------------------------------------
module sars_sqrt_cell #(
	parameter int ROOT_W = 14,
	parameter int X_W    = 28,
	parameter int SIDE_W = 21
) (
	input  logic              clk,
	input  logic [X_W-1:0]    x_in,
	input  logic [ROOT_W+1:0] rem_in,
	input  logic [ROOT_W-1:0] root_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic [X_W-1:0]    x_out,
	output logic [ROOT_W+1:0] rem_out,
	output logic [ROOT_W-1:0] root_out,
	output logic [SIDE_W-1:0] side_out
);

	logic [ROOT_W+1:0] rem4;
	logic [ROOT_W+1:0] trial;
	logic              fits;

	assign rem4  = {rem_in[ROOT_W-1:0], x_in[X_W-1 -: 2]};
	assign trial = {root_in, 2'b01};
	assign fits  = rem4 >= trial;

	always_ff @(posedge clk) begin
		x_out    <= {x_in[X_W-3:0], 2'b00};
		rem_out  <= fits ? (rem4 - trial) : rem4;
		root_out <= {root_in[ROOT_W-2:0], fits};
		side_out <= side_in;
	end

endmodule

[rtl/sars_axis.sv]
// ----------------------------------------------------------------------------
// sars_axis
// One axis: magnitude and small-error test, square-root cell chain, gain
// scaling with rounding, saturation and sign restore.
// ----------------------------------------------------------------------------
module sars_axis #(
	parameter int ANGLE_WIDTH = sars_pkg::ANGLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic [sars_pkg::ERR_W-1:0]    err,
	input  logic [sars_pkg::GAIN_W-1:0]   gain,
	input  logic [sars_pkg::LIMIT_W-1:0]  limit,
	output logic [sars_pkg::RATE_W-1:0]   rate,
	output logic                          clip
);

	localparam int AW     = ANGLE_WIDTH;
	localparam int SQ_W   = sars_pkg::sqrt_w(ANGLE_WIDTH);
	localparam int X_W    = 2 * SQ_W;
	localparam int REM_W  = SQ_W + 2;
	localparam int SIDE_W = 2 + sars_pkg::F_W;
	localparam int P1_W   = sars_pkg::GAIN_W + SQ_W;
	localparam int MAG_W  = SQ_W + 5;
	localparam int PROD_W = sars_pkg::P1_SMALL_W + sars_pkg::F_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int Q_W    = SUM_W - sars_pkg::Q_SHIFT;
	localparam int QM_W   = Q_W + sars_pkg::RECIP_W;
	localparam int MS_W   = QM_W - sars_pkg::RECIP_SHIFT;

	logic [AW-1:0]              v;
	logic                       neg;
	logic [AW-1:0]              a;
	logic                       is_small;
	logic [sars_pkg::F_W-1:0]   f;

	logic [X_W-1:0]             x_s1;
	logic                       neg_s1;
	logic                       small_s1;
	logic [sars_pkg::F_W-1:0]   f_s1;

	logic [X_W-1:0]    x_c    [0:SQ_W-1];
	logic [REM_W-1:0]  rem_c  [0:SQ_W-1];
	logic [SQ_W-1:0]   root_c [0:SQ_W];
	logic [SIDE_W-1:0] side_c [0:SQ_W];

	logic [SQ_W-1:0]            root;
	logic                       neg_c;
	logic                       small_c;
	logic [sars_pkg::F_W-1:0]   f_c;

	logic [P1_W-1:0]            p1_s2;
	logic                       neg_s2;
	logic                       small_s2;
	logic [sars_pkg::F_W-1:0]   f_s2;

	logic [P1_W:0]              big_sum;
	logic [PROD_W-1:0]          prod_s3;
	logic [MAG_W-1:0]           big_s3;
	logic                       neg_s3;
	logic                       small_s3;

	logic [SUM_W-1:0]           sum;
	logic [Q_W-1:0]             q_s4;
	logic [MAG_W-1:0]           big_s4;
	logic                       neg_s4;
	logic                       small_s4;

	logic [QM_W-1:0]            qm;
	logic [MS_W-1:0]            mag_small_s5;
	logic [MAG_W-1:0]           big_s5;
	logic                       neg_s5;
	logic                       small_s5;

	logic [MAG_W-1:0]                mag;
	logic                            over;
	logic [sars_pkg::LIMIT_W-1:0]    mag_c;
	logic [sars_pkg::RATE_W-1:0]     pos;
	logic [sars_pkg::RATE_W-1:0]     rate_s6;
	logic                            clip_s6;

	// entry: magnitude, small-error test, linear factor
	assign v        = AW'(err);
	assign neg      = v[AW-1];
	assign a        = neg ? (~v + AW'(1)) : v;
	assign is_small = a < AW'(sars_pkg::SMALL_LIMIT);
	assign f        = sars_pkg::F_W'(a[sars_pkg::SMALL_A_W-1:0]) *
	                  sars_pkg::F_W'(sars_pkg::SMALL_NUM);

	always_ff @(posedge clk) begin
		x_s1     <= X_W'({a, {sars_pkg::FRAC_W{1'b0}}});
		neg_s1   <= neg;
		small_s1 <= is_small;
		f_s1     <= f;
	end

	// square-root cell chain, one root bit per cell
	assign x_c[0]    = x_s1;
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;
	assign side_c[0] = {neg_s1, small_s1, f_s1};

	for (genvar i = 0; i < SQ_W; i++) begin : g_cell
		if (i < SQ_W - 1) begin : g_mid
			sars_sqrt_cell #(
				.ROOT_W (SQ_W),
				.X_W    (X_W),
				.SIDE_W (SIDE_W)
			) u_cell (
				.clk      (clk),
				.x_in     (x_c[i]),
				.rem_in   (rem_c[i]),
				.root_in  (root_c[i]),
				.side_in  (side_c[i]),
				.x_out    (x_c[i+1]),
				.rem_out  (rem_c[i+1]),
				.root_out (root_c[i+1]),
				.side_out (side_c[i+1])
			);
		end else begin : g_last
			sars_sqrt_cell #(
				.ROOT_W (SQ_W),
				.X_W    (X_W),
				.SIDE_W (SIDE_W)
			) u_cell (
				.clk      (clk),
				.x_in     (x_c[i]),
				.rem_in   (rem_c[i]),
				.root_in  (root_c[i]),
				.side_in  (side_c[i]),
				.x_out    (),
				.rem_out  (),
				.root_out (root_c[i+1]),
				.side_out (side_c[i+1])
			);
		end
	end

	assign root                  = root_c[SQ_W];
	assign {neg_c, small_c, f_c} = side_c[SQ_W];

	// gain times root
	always_ff @(posedge clk) begin
		p1_s2    <= P1_W'(gain) * P1_W'(root);
		neg_s2   <= neg_c;
		small_s2 <= small_c;
		f_s2     <= f_c;
	end

	// small region: times linear factor; large region: round off fraction
	assign big_sum = (P1_W + 1)'(p1_s2) + (P1_W + 1)'(sars_pkg::ROUND_HALF);

	always_ff @(posedge clk) begin
		prod_s3  <= PROD_W'(p1_s2[sars_pkg::P1_SMALL_W-1:0]) * PROD_W'(f_s2);
		big_s3   <= big_sum[P1_W:sars_pkg::FRAC_W];
		neg_s3   <= neg_s2;
		small_s3 <= small_s2;
	end

	assign sum = SUM_W'(prod_s3) + SUM_W'(sars_pkg::ROUND_OFS);

	always_ff @(posedge clk) begin
		q_s4     <= sum[SUM_W-1:sars_pkg::Q_SHIFT];
		big_s4   <= big_s3;
		neg_s4   <= neg_s3;
		small_s4 <= small_s3;
	end

	// divide by 100 via reciprocal
	assign qm = QM_W'(q_s4) * QM_W'(sars_pkg::RECIP);

	always_ff @(posedge clk) begin
		mag_small_s5 <= qm[QM_W-1:sars_pkg::RECIP_SHIFT];
		big_s5       <= big_s4;
		neg_s5       <= neg_s4;
		small_s5     <= small_s4;
	end

	// saturate and restore sign
	assign mag   = small_s5 ? MAG_W'(mag_small_s5) : big_s5;
	assign over  = mag > MAG_W'(limit);
	assign mag_c = over ? limit : mag[sars_pkg::LIMIT_W-1:0];
	assign pos   = {1'b0, mag_c};

	always_ff @(posedge clk) begin
		rate_s6 <= neg_s5 ? (~pos + sars_pkg::RATE_W'(1)) : pos;
		clip_s6 <= over;
	end

	assign rate = rate_s6;
	assign clip = clip_s6;

endmodule

[rtl/sqrt_attitude_rate_shaper.sv]
// ----------------------------------------------------------------------------
// sqrt_attitude_rate_shaper
// Turns roll, pitch and yaw angle errors into saturated desired rates
// sign(e) * k * sqrt(|e|), with k tapered linearly for small errors.
//
// An error beat is taken at each rising edge with start high and busy low;
// busy stays low, so a new beat may come every cycle. The result beat shows
// on rate_cmd with done high for exactly one cycle and must be taken then.
// Each beat passes the entry stage, then one square-root cell per root
// bit in the cell chain of each axis, then the two multiply, rounding,
// reciprocal divide and saturation stages, registered in that order.
// Throughput is one beat per cycle, all three axes in parallel.
// peak_gain (index 0) and rate_limit (index 1) are written through the
// cfg channel, always ready; other indexes are ignored. Write them only
// while no beat is in flight. Reset clears the in-flight beats and loads
// peak_gain = sqrt(pi) and rate_limit = pi.
// ----------------------------------------------------------------------------
module sqrt_attitude_rate_shaper #(
	parameter int ANGLE_WIDTH = sars_pkg::ANGLE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  sars_pkg::err_vec_t                attitude_err,
	output logic                              done,
	output sars_pkg::rate_vec_t               rate_cmd,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sars_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sars_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int LAT = sars_pkg::sqrt_w(ANGLE_WIDTH) + sars_pkg::POST_STAGES;

	logic [sars_pkg::GAIN_W-1:0]  peak_gain_q;
	logic [sars_pkg::LIMIT_W-1:0] rate_limit_q;
	logic [LAT-1:0]               vld_q;
	logic [sars_pkg::CLIP_W-1:0]  clip;
	logic [sars_pkg::RATE_W-1:0]  lim_pos;
	logic [sars_pkg::RATE_W-1:0]  lim_neg;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_gain_q  <= sars_pkg::GAIN_RESET;
			rate_limit_q <= sars_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sars_pkg::REG_PEAK_GAIN: begin
					peak_gain_q <= cfg_data;
				end
				sars_pkg::REG_RATE_LIMIT: begin
					rate_limit_q <= cfg_data[sars_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end

	assign done = vld_q[LAT-1];

	sars_axis #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_roll (
		.clk   (clk),
		.err   (attitude_err.err_roll),
		.gain  (peak_gain_q),
		.limit (rate_limit_q),
		.rate  (rate_cmd.rate_roll),
		.clip  (clip[0])
	);

	sars_axis #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_pitch (
		.clk   (clk),
		.err   (attitude_err.err_pitch),
		.gain  (peak_gain_q),
		.limit (rate_limit_q),
		.rate  (rate_cmd.rate_pitch),
		.clip  (clip[1])
	);

	sars_axis #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_yaw (
		.clk   (clk),
		.err   (attitude_err.err_yaw),
		.gain  (peak_gain_q),
		.limit (rate_limit_q),
		.rate  (rate_cmd.rate_yaw),
		.clip  (clip[2])
	);

	assign rate_cmd.clip_mask = clip;

	assign lim_pos = {1'b0, rate_limit_q};
	assign lim_neg = ~lim_pos + sars_pkg::RATE_W'(1);

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result beat without matching input beat");

	a_roll_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done && rate_cmd.clip_mask[0] |->
			(rate_cmd.rate_roll == lim_pos) || (rate_cmd.rate_roll == lim_neg))
		else $error("roll clipped but rate not at limit");

	a_yaw_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done && rate_cmd.clip_mask[2] |->
			(rate_cmd.rate_yaw == lim_pos) || (rate_cmd.rate_yaw == lim_neg))
		else $error("yaw clipped but rate not at limit");

	a_zero_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rate_limit_q == '0) |->
			(rate_cmd.rate_roll == '0) && (rate_cmd.rate_pitch == '0) &&
			(rate_cmd.rate_yaw == '0))
		else $error("nonzero rate under zero limit");

endmodule

[test/sqrt_attitude_rate_shaper_tb.sv]
// ----------------------------------------------------------------------------
// sqrt_attitude_rate_shaper_tb
// Self-checking bench for the square-root attitude rate shaper. Angle error
// beats go in on start/busy and rate beats come back on done. Every rate beat
// is checked field by field against a fixed row result or a bit-exact shaping
// model that tracks the gain and limit registers. A short directed table runs
// first, right after reset. Random beats follow under several register settings,
// including the gain and limit extremes, with random gaps bar the first setting.
// ----------------------------------------------------------------------------
module sqrt_attitude_rate_shaper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sars_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam logic [63:0] TAPER_NUM  = 64'd573;
	localparam logic [63:0] TAPER_FULL = 64'd409600;
	localparam logic [63:0] ROUND_DIV  = 64'd1677721600;

	localparam int BEATS_PER_SETTING = 256;
	localparam int SETTINGS_N        = 6;
	localparam int IDLE_PCT          = 19;
	localparam int DRAIN_CYCLES      = 24;

	typedef struct {
		err_vec_t  err;
		bit        fixed;
		rate_vec_t want;
	} err_row_t;

	localparam int DIR_N = 10;

	// rows with fixed results assume the reset gain and limit
	err_row_t dir_rows [DIR_N] = '{
		'{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 3'b000}},
		'{'{16'sd32767, -16'sd32768, 16'sd0}, 1'b1,
			'{16'sd12868, -16'sd12868, 16'sd0, 3'b011}},
		'{'{16'sd1, -16'sd1, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 3'b000}},
		'{'{-16'sd32768, 16'sd32767, -16'sd32768}, 1'b1,
			'{-16'sd12868, 16'sd12868, -16'sd12868, 3'b111}},
		'{'{16'sd714, 16'sd715, -16'sd714}, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 3'b000}},
		'{'{-16'sd715, 16'sd716, 16'sd713}, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 3'b000}},
		'{'{16'sh5555, 16'shAAAA, 16'sh7FFF}, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 3'b000}},
		'{'{16'sh8001, 16'sh4000, 16'sh0800}, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 3'b000}},
		'{'{16'sh00FF, 16'shFF00, 16'sh1234}, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 3'b000}},
		'{'{16'sd100, -16'sd100, 16'sd4096}, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 3'b000}}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	err_vec_t              attitude_err = '0;
	logic                  done;
	rate_vec_t             rate_cmd;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bit                    beat_fixed = 1'b0;
	rate_vec_t             beat_want = '0;

	logic [GAIN_W-1:0]     gain_reg = GAIN_RESET;
	logic [LIMIT_W-1:0]    limit_reg = LIMIT_RESET;
	rate_vec_t             pending_rates [$];
	int unsigned           mismatches = 0;

	sqrt_attitude_rate_shaper dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.attitude_err (attitude_err),
		.done         (done),
		.rate_cmd     (rate_cmd),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// returns {clipped, rate}
	function automatic logic [RATE_W:0] shape_axis(logic signed [ERR_W-1:0] e,
			logic [GAIN_W-1:0] gain, logic [LIMIT_W-1:0] lim);
		logic [ERR_W-1:0]  a;
		logic [31:0]       sq;
		logic [14:0]       root;
		logic [14:0]       cand;
		logic [63:0]       f;
		logic [63:0]       mag;
		logic              clip;
		logic [RATE_W-1:0] rate;
		a = e[ERR_W-1] ? (~e + 16'd1) : e;
		sq = {4'b0, a, 12'b0};
		root = '0;
		for (int b = 14; b >= 0; b--) begin
			cand = root | (15'd1 << b);
			if (32'(cand) * 32'(cand) <= sq)
				root = cand;
		end
		f = (64'(a) * TAPER_NUM < TAPER_FULL) ? 64'(a) * TAPER_NUM : TAPER_FULL;
		mag = (64'(gain) * 64'(root) * f + ROUND_DIV / 2) / ROUND_DIV;
		clip = mag > 64'(lim);
		if (clip)
			mag = 64'(lim);
		rate = e[ERR_W-1] ? (~mag[RATE_W-1:0] + 16'd1) : mag[RATE_W-1:0];
		return {clip, rate};
	endfunction

	function automatic rate_vec_t predict_rates(err_vec_t v, logic [GAIN_W-1:0] gain,
			logic [LIMIT_W-1:0] lim);
		rate_vec_t       r;
		logic [RATE_W:0] x;
		x = shape_axis(v.err_roll, gain, lim);
		r.rate_roll = x[RATE_W-1:0];
		r.clip_mask[0] = x[RATE_W];
		x = shape_axis(v.err_pitch, gain, lim);
		r.rate_pitch = x[RATE_W-1:0];
		r.clip_mask[1] = x[RATE_W];
		x = shape_axis(v.err_yaw, gain, lim);
		r.rate_yaw = x[RATE_W-1:0];
		r.clip_mask[2] = x[RATE_W];
		return r;
	endfunction

	function automatic logic signed [ERR_W-1:0] rand_angle();
		logic signed [ERR_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = 16'($urandom);
			4, 5: v = 16'($urandom_range(0, 1023));
			6: v = 16'($urandom_range(SMALL_LIMIT - 3, SMALL_LIMIT + 2));
			7: begin
				case ($urandom_range(0, 4))
					0: v = 16'sd0;
					1: v = 16'sd1;
					2: v = -16'sd1;
					3: v = 16'sd32767;
					default: v = -16'sd32768;
				endcase
			end
			default: v = 16'($urandom_range(0, 8191));
		endcase
		if ($urandom_range(0, 1) && v > 0)
			v = -v;
		return v;
	endfunction

	task automatic note_field(string name, logic [RATE_W-1:0] want, logic [RATE_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %h, got %h", name, want, got);
		end
	endtask

	// scoreboard and register shadow
	always @(posedge clk) begin
		rate_vec_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_rates.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected rate beat %h", rate_cmd);
				end else begin
					want = pending_rates.pop_front();
					note_field("rate_roll", want.rate_roll, rate_cmd.rate_roll);
					note_field("rate_pitch", want.rate_pitch, rate_cmd.rate_pitch);
					note_field("rate_yaw", want.rate_yaw, rate_cmd.rate_yaw);
					note_field("clip_mask", 16'(want.clip_mask), 16'(rate_cmd.clip_mask));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PEAK_GAIN: gain_reg = cfg_data[GAIN_W-1:0];
					REG_RATE_LIMIT: limit_reg = cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy)
				pending_rates.push_back(beat_fixed ? beat_want
					: predict_rates(attitude_err, gain_reg, limit_reg));
		end
	end

	task automatic send_err(err_vec_t v, bit fixed, rate_vec_t want, int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		attitude_err <= v;
		beat_fixed <= fixed;
		beat_want <= want;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic drain_rates();
		start <= 1'b0;
		do @(negedge clk); while (pending_rates.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic load_regs(logic [CFG_DATA_W-1:0] gain, logic [CFG_DATA_W-1:0] lim);
		write_reg(REG_PEAK_GAIN, gain);
		write_reg(REG_RATE_LIMIT, lim);
		write_reg(REG_SPARE_2, 16'($urandom));
		write_reg(REG_SPARE_3, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] set_gain [SETTINGS_N];
		logic [CFG_DATA_W-1:0] set_limit [SETTINGS_N];
		err_vec_t              v;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_N; i++)
			send_err(dir_rows[i].err, dir_rows[i].fixed, dir_rows[i].want, IDLE_PCT);
		drain_rates();

		// limit equal to the unclipped rate is not flagged
		load_regs(GAIN_RESET, 16'd7260);
		send_err('{16'sd4096, -16'sd4096, 16'sd4100}, 1'b0, '0, IDLE_PCT);
		send_err('{16'sd4100, 16'sd0, -16'sd4100}, 1'b0, '0, IDLE_PCT);
		drain_rates();

		set_gain = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom), GAIN_RESET};
		set_limit = '{16'hFFFF, 16'h7FFF, 16'h0000, 16'($urandom),
			16'($urandom_range(0, 2047)), 16'(LIMIT_RESET)};
		for (int s = 0; s < SETTINGS_N; s++) begin
			load_regs(set_gain[s], set_limit[s]);
			for (int n = 0; n < BEATS_PER_SETTING; n++) begin
				v.err_roll = rand_angle();
				v.err_pitch = rand_angle();
				v.err_yaw = rand_angle();
				send_err(v, 1'b0, '0, (s == 0) ? 0 : IDLE_PCT);
			end
			drain_rates();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_rates.size() == 0)
			$display("** sqrt_attitude_rate_shaper: PASSED **");
		else
			$display("** sqrt_attitude_rate_shaper: FAILED **");
		$finish;
	end

	initial begin
		#2400000;
		$display("** sqrt_attitude_rate_shaper: FAILED **");
		$finish;
	end

endmodule
